// ===== src/ppt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the palindromic prime test block.
package ppt_pkg;

    localparam int DIGIT_W       = 4;
    localparam int DABBLE_LIMIT  = 5;
    localparam int DABBLE_ADD    = 3;
    localparam int FIRST_DIVISOR = 2;
    localparam int ECHO_W        = 32;

    typedef struct packed {
        logic done;
        logic result;
    } unit_status_t;

endpackage

// ===== src/ppt_pal_check.sv =====
`timescale 1ns / 1ps
// Decimal palindrome check: serial binary to BCD conversion and digit-serial compare.
module ppt_pal_check #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] number,
    output ppt_pkg::unit_status_t  status
);

    localparam int NUM_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
    localparam int BCD_W      = NUM_DIGITS * ppt_pkg::DIGIT_W;
    localparam int CNT_W      = $clog2(NUM_DIGITS + 1);
    localparam int BIT_W      = $clog2(VALUE_WIDTH + 1);

    typedef enum logic [2:0] {
        P_IDLE,
        P_CONVERT,
        P_NORM,
        P_COMPARE,
        P_DONE
    } pal_state_t;

    pal_state_t                   state_reg;
    logic [VALUE_WIDTH-1:0]       shift_reg;
    logic [BCD_W-1:0]             bcd_reg;
    logic [BCD_W-1:0]             norm_reg;
    logic [BIT_W-1:0]             bit_cnt_reg;
    logic [CNT_W-1:0]             digit_cnt_reg;
    logic                         match_reg;

    logic [BCD_W-1:0]             adjusted;
    logic [BCD_W-1:0]             bcd_shifted;
    logic [ppt_pkg::DIGIT_W-1:0]  norm_top;
    logic [ppt_pkg::DIGIT_W-1:0]  orig_low;

    always_comb
    begin
        logic [ppt_pkg::DIGIT_W-1:0] digit;
        digit = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            digit = bcd_reg[i*ppt_pkg::DIGIT_W +: ppt_pkg::DIGIT_W];
            if (digit >= ppt_pkg::DIGIT_W'(ppt_pkg::DABBLE_LIMIT))
            begin
                digit = digit + ppt_pkg::DIGIT_W'(ppt_pkg::DABBLE_ADD);
            end
            adjusted[i*ppt_pkg::DIGIT_W +: ppt_pkg::DIGIT_W] = digit;
        end
    end

    assign bcd_shifted = {adjusted[BCD_W-2:0], shift_reg[VALUE_WIDTH-1]};
    assign norm_top    = norm_reg[BCD_W-1 -: ppt_pkg::DIGIT_W];
    assign orig_low    = bcd_reg[ppt_pkg::DIGIT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            match_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                P_IDLE, P_DONE:
                begin
                    if (start)
                    begin
                        shift_reg   <= number;
                        bcd_reg     <= '0;
                        bit_cnt_reg <= BIT_W'(VALUE_WIDTH);
                        state_reg   <= P_CONVERT;
                    end
                end
                P_CONVERT:
                begin
                    bcd_reg     <= bcd_shifted;
                    shift_reg   <= shift_reg << 1;
                    bit_cnt_reg <= bit_cnt_reg - BIT_W'(1);
                    if (bit_cnt_reg == BIT_W'(1))
                    begin
                        norm_reg      <= bcd_shifted;
                        digit_cnt_reg <= CNT_W'(NUM_DIGITS);
                        state_reg     <= P_NORM;
                    end
                end
                P_NORM:
                begin
                    if (norm_top == '0 && digit_cnt_reg != CNT_W'(1))
                    begin
                        norm_reg      <= norm_reg << ppt_pkg::DIGIT_W;
                        digit_cnt_reg <= digit_cnt_reg - CNT_W'(1);
                    end
                    else
                    begin
                        match_reg <= 1'b1;
                        state_reg <= P_COMPARE;
                    end
                end
                P_COMPARE:
                begin
                    if (norm_top != orig_low)
                    begin
                        match_reg <= 1'b0;
                    end
                    norm_reg      <= norm_reg << ppt_pkg::DIGIT_W;
                    bcd_reg       <= bcd_reg >> ppt_pkg::DIGIT_W;
                    digit_cnt_reg <= digit_cnt_reg - CNT_W'(1);
                    if (digit_cnt_reg == CNT_W'(1))
                    begin
                        state_reg <= P_DONE;
                    end
                end
                default:
                begin
                    state_reg <= P_IDLE;
                end
            endcase
        end
    end

    assign status.done   = (state_reg == P_DONE);
    assign status.result = match_reg;

endmodule

// ===== src/ppt_trial_div.sv =====
`timescale 1ns / 1ps
// Primality check by trial division with a bit-serial restoring divider.
module ppt_trial_div #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] number,
    output ppt_pkg::unit_status_t  status
);

    localparam int BIT_W = $clog2(VALUE_WIDTH + 1);

    typedef enum logic [1:0] {
        T_IDLE,
        T_DIVIDE,
        T_CHECK,
        T_DONE
    } div_state_t;

    div_state_t             state_reg;
    logic [VALUE_WIDTH-1:0] n_reg;
    logic [VALUE_WIDTH-1:0] div_reg;
    logic [VALUE_WIDTH-1:0] rem_reg;
    logic [VALUE_WIDTH-1:0] quo_reg;
    logic [BIT_W-1:0]       bit_cnt_reg;
    logic                   prime_reg;

    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;
    logic                   fits;

    assign trial = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = (trial >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            prime_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                T_IDLE, T_DONE:
                begin
                    if (start)
                    begin
                        if (number < VALUE_WIDTH'(ppt_pkg::FIRST_DIVISOR))
                        begin
                            prime_reg <= 1'b0;
                            state_reg <= T_DONE;
                        end
                        else
                        begin
                            n_reg       <= number;
                            quo_reg     <= number;
                            rem_reg     <= '0;
                            div_reg     <= VALUE_WIDTH'(ppt_pkg::FIRST_DIVISOR);
                            bit_cnt_reg <= BIT_W'(VALUE_WIDTH);
                            state_reg   <= T_DIVIDE;
                        end
                    end
                end
                T_DIVIDE:
                begin
                    rem_reg     <= fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
                    quo_reg     <= {quo_reg[VALUE_WIDTH-2:0], fits};
                    bit_cnt_reg <= bit_cnt_reg - BIT_W'(1);
                    if (bit_cnt_reg == BIT_W'(1))
                    begin
                        state_reg <= T_CHECK;
                    end
                end
                T_CHECK:
                begin
                    priority if (div_reg > quo_reg)
                    begin
                        prime_reg <= 1'b1;
                        state_reg <= T_DONE;
                    end
                    else if (rem_reg == '0)
                    begin
                        prime_reg <= 1'b0;
                        state_reg <= T_DONE;
                    end
                    else
                    begin
                        div_reg     <= div_reg + VALUE_WIDTH'(1);
                        quo_reg     <= n_reg;
                        rem_reg     <= '0;
                        bit_cnt_reg <= BIT_W'(VALUE_WIDTH);
                        state_reg   <= T_DIVIDE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign status.done   = (state_reg == T_DONE);
    assign status.result = prime_reg;

endmodule

// ===== src/palindromic_prime_test_top.sv =====
`timescale 1ns / 1ps
// Top level of the palindromic prime test: handshakes, result register and the two check units.
//
//  Channel   Signals                                     Direction  Word
//  cand      cand_valid, cand_ready, candidate           in         one number to test
//  result    result_valid, result_ready, number_echo,    out        one verdict per number
//            is_palindrome, is_prime, is_palindromic_prime
//
// The palindrome check works by serial BCD conversion and compare. The prime check runs each
// trial divisor through the bit-serial divider, up to about 2^(VALUE_WIDTH/2) divisors.
// Both checks run side by side; one word is in work at a time.
// A new word is accepted once the previous verdict sits in the result register, even if stalled.
// Reset is asynchronous, active low, and needs no clearing pass.
module palindromic_prime_test_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cand_valid,
    output logic                          cand_ready,
    input  logic [VALUE_WIDTH-1:0]        candidate,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [ppt_pkg::ECHO_W-1:0]    number_echo,
    output logic                          is_palindrome,
    output logic                          is_prime,
    output logic                          is_palindromic_prime
);

    logic                          busy_reg;
    logic [VALUE_WIDTH-1:0]        number_reg;
    logic                          result_valid_reg;
    logic [ppt_pkg::ECHO_W-1:0]    echo_reg;
    logic                          pal_reg;
    logic                          prime_reg;
    logic                          both_reg;

    logic                          start;
    logic                          finish;
    logic [ppt_pkg::ECHO_W-1:0]    echo_value;
    ppt_pkg::unit_status_t         pal_status;
    ppt_pkg::unit_status_t         prime_status;

    assign cand_ready = !busy_reg;
    assign start      = cand_valid && cand_ready;
    assign finish     = busy_reg && pal_status.done && prime_status.done
                        && (!result_valid_reg || result_ready);

    generate
        if (VALUE_WIDTH >= ppt_pkg::ECHO_W)
        begin : g_echo_trunc
            assign echo_value = number_reg[ppt_pkg::ECHO_W-1:0];
        end
        else
        begin : g_echo_ext
            assign echo_value = {{(ppt_pkg::ECHO_W - VALUE_WIDTH){1'b0}}, number_reg};
        end
    endgenerate

    ppt_pal_check #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_pal (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .number (candidate),
        .status (pal_status)
    );

    ppt_trial_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_prime (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .number (candidate),
        .status (prime_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                busy_reg   <= 1'b1;
                number_reg <= candidate;
            end
            priority if (finish)
            begin
                busy_reg         <= 1'b0;
                result_valid_reg <= 1'b1;
                echo_reg         <= echo_value;
                pal_reg          <= pal_status.result;
                prime_reg        <= prime_status.result;
                both_reg         <= pal_status.result && prime_status.result;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid         = result_valid_reg;
    assign number_echo          = echo_reg;
    assign is_palindrome        = pal_reg;
    assign is_prime             = prime_reg;
    assign is_palindromic_prime = both_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !cand_ready)
        else $error("input still ready after a word was accepted");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(busy_reg))
        else $error("result appeared without a word in work");

    a_both_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (is_palindromic_prime == (is_palindrome && is_prime)))
        else $error("combined flag disagrees with the two checks");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the palindromic prime test block with random stalls.
module tb_top;

    localparam int VALUE_WIDTH = 32;
    localparam int RADIX       = 10;
    localparam int MAX_DIGITS  = 10;
    localparam int HOLD_CYCLES = 2000;
    localparam int TAIL_CYCLES = 200;
    localparam int SHOWN_LIMIT = 10;

    typedef struct packed {
        logic [ppt_pkg::ECHO_W-1:0] number;
        logic                       pal;
        logic                       prime;
        logic                       pal_prime;
    } verdict_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cand_valid;
    logic                         cand_ready;
    logic [VALUE_WIDTH-1:0]       candidate;
    logic                         result_valid;
    logic                         result_ready;
    logic [ppt_pkg::ECHO_W-1:0]   number_echo;
    logic                         is_palindrome;
    logic                         is_prime;
    logic                         is_palindromic_prime;

    verdict_t        verdicts_due[$];
    int unsigned     mismatches;
    bit              steady;
    bit              hold_request;
    longint unsigned cycle_count;
    longint unsigned cycle_budget;

    palindromic_prime_test_top #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) DUT (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cand_valid           (cand_valid),
        .cand_ready           (cand_ready),
        .candidate            (candidate),
        .result_valid         (result_valid),
        .result_ready         (result_ready),
        .number_echo          (number_echo),
        .is_palindrome        (is_palindrome),
        .is_prime             (is_prime),
        .is_palindromic_prime (is_palindromic_prime)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > cycle_budget)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic bit reads_same_reversed(input logic [VALUE_WIDTH-1:0] n);
        int unsigned     digs[MAX_DIGITS];
        int              cnt;
        int              lo;
        int              hi;
        longint unsigned rest;
        rest = n;
        cnt  = 0;
        do
        begin
            digs[cnt] = 32'(rest % RADIX);
            cnt++;
            rest = rest / RADIX;
        end
        while (rest != 0);
        lo = 0;
        hi = cnt - 1;
        while (lo < hi)
        begin
            if (digs[lo] != digs[hi])
                return 1'b0;
            lo++;
            hi--;
        end
        return 1'b1;
    endfunction

    function automatic bit survives_trial_division(input logic [VALUE_WIDTH-1:0] n,
                                                   output int unsigned trials);
        longint unsigned num;
        longint unsigned d;
        num    = n;
        trials = 0;
        if (num < ppt_pkg::FIRST_DIVISOR)
            return 1'b0;
        for (d = ppt_pkg::FIRST_DIVISOR; d <= num / d; d++)
        begin
            trials++;
            if (num % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic verdict_t judge_number(input logic [VALUE_WIDTH-1:0] n,
                                              output int unsigned trials);
        verdict_t v;
        v.number    = n;
        v.pal       = reads_same_reversed(n);
        v.prime     = survives_trial_division(n, trials);
        v.pal_prime = v.pal & v.prime;
        return v;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic offer_number(input logic [VALUE_WIDTH-1:0] n);
        verdict_t    v;
        int unsigned trials;
        int unsigned gap;
        v = judge_number(n, trials);
        cycle_budget += 4 * ((VALUE_WIDTH + 1) * (trials + 2) + 300);
        cand_valid <= 1'b1;
        candidate  <= n;
        do
            @(posedge clk);
        while (!cand_ready);
        verdicts_due.push_back(v);
        gap = pick_gap();
        if (gap > 0)
        begin
            cand_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic go_quiet(input int unsigned cycles);
        cand_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic check_verdict();
        verdict_t want;
        if (verdicts_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= SHOWN_LIMIT)
                $display("Unexpected result word: number %0d", number_echo);
        end
        else
        begin
            want = verdicts_due.pop_front();
            if (number_echo !== want.number || is_palindrome !== want.pal ||
                is_prime !== want.prime || is_palindromic_prime !== want.pal_prime)
            begin
                mismatches++;
                if (mismatches <= SHOWN_LIMIT)
                    $display("Mismatch: want %0d pal/prime/both %0b%0b%0b, got %0d %0b%0b%0b",
                             want.number, want.pal, want.prime, want.pal_prime,
                             number_echo, is_palindrome, is_prime, is_palindromic_prime);
            end
        end
    endtask

    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
                check_verdict();
            if (hold_request)
            begin
                stall_left   = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    task automatic test_corner_values();
        logic [31:0] corner_values[25] = '{
            0, 1, 2, 3, 4, 9, 10, 11, 12, 101, 121, 131, 929, 1001, 10301, 12321, 99999,
            65537, 1046527, 16777213, 32'd4294967295, 32'h80000000, 32'hAAAAAAAA,
            32'h55555555, 32'd4294884924
        };
        foreach (corner_values[i])
            offer_number(corner_values[i]);
        go_quiet(1);
    endtask

    task automatic test_back_to_back();
        int i;
        steady = 1'b1;
        for (i = 0; i < 20; i++)
            offer_number($urandom_range(0, 4095));
        go_quiet(1);
        steady = 1'b0;
    endtask

    task automatic test_output_hold();
        int i;
        cycle_budget += HOLD_CYCLES;
        hold_request = 1'b1;
        for (i = 0; i < 6; i++)
            offer_number($urandom_range(0, 4095));
        go_quiet(1);
    endtask

    task automatic test_random_mix(input int unsigned count);
        int unsigned     i;
        int unsigned     k;
        int unsigned     kind;
        int unsigned     ndig;
        int unsigned     digs[7];
        logic [31:0]     n;
        for (i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 35)
                n = $urandom_range(0, 32'h0000FFFF);
            else if (kind < 55)
                n = $urandom_range(0, 32'h000FFFFF);
            else if (kind < 80)
            begin
                // Mostly short palindromes; a seven-digit one now and then.
                ndig = ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(1, 6);
                for (k = 0; k < (ndig + 1) / 2; k++)
                begin
                    digs[k] = (k == 0 && ndig > 1) ? $urandom_range(1, 9) : $urandom_range(0, 9);
                    digs[ndig - 1 - k] = digs[k];
                end
                n = 0;
                for (k = 0; k < ndig; k++)
                    n = n * RADIX + digs[k];
            end
            else
            begin
                // Wide values with a small factor keep the trial division short.
                k = $urandom_range(2, 13);
                n = $urandom;
                n = n - n % k;
            end
            offer_number(n);
        end
        go_quiet(1);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cand_valid   = 1'b0;
        candidate    = '0;
        result_ready = 1'b0;
        mismatches   = 0;
        steady       = 1'b0;
        hold_request = 1'b0;
        cycle_count  = 0;
        cycle_budget = 50000;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_values();
        test_back_to_back();
        test_output_hold();
        test_random_mix(50);

        cycle_budget += 4 * TAIL_CYCLES;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
